>>> src/gaec_pkg.sv
// Shared codes, widths and sequencer states for the graph adjacency Euler check block.
`timescale 1ns / 1ps

package gaec_pkg;

    localparam int MODE_W   = 3;
    localparam int VERT_W   = 5;
    localparam int STATUS_W = 3;
    localparam int VCOUNT_W = 5;
    localparam int ECOUNT_W = 7;
    localparam int DEGREE_W = 4;

    localparam logic [MODE_W-1:0] MODE_ADD_VERTEX = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD_EDGE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DEL_VERTEX = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_EDGE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEGREE     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_COUNTS     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_EULER      = 3'd6;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_VERT = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NO_EDGE = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd4;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_DECODE    = 13'b0000000000010,
        S_EDGE_RD_A = 13'b0000000000100,
        S_EDGE_WR_A = 13'b0000000001000,
        S_EDGE_RD_B = 13'b0000000010000,
        S_EDGE_WR_B = 13'b0000000100000,
        S_DEL_RD    = 13'b0000001000000,
        S_DEL_WR    = 13'b0000010000000,
        S_DEG_RD    = 13'b0000100000000,
        S_DEG_CAP   = 13'b0001000000000,
        S_EUL_SCAN  = 13'b0010000000000,
        S_CNT_SCAN  = 13'b0100000000000,
        S_FIN       = 13'b1000000000000
    } state_t;

endpackage

>>> src/gaec_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gaec_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> src/gaec_popcount.sv
// Set-bit counter for one adjacency row, built as a balanced adder tree.
`timescale 1ns / 1ps

module gaec_popcount #(
    parameter int WIDTH = 16
) (
    input  logic [WIDTH-1:0]           row,
    output logic [$clog2(WIDTH+1)-1:0] count
);

    localparam int CW     = $clog2(WIDTH + 1);
    localparam int LEVELS = $clog2(WIDTH);
    localparam int LEAVES = 1 << LEVELS;

    // heap layout: node j sums nodes 2j and 2j+1, leaves start at LEAVES
    logic [CW-1:0] tree [1:2*LEAVES-1];

    genvar k;
    generate
        for (k = 0; k < LEAVES; k++)
        begin : g_leaf
            if (k < WIDTH)
            begin : g_bit
                assign tree[LEAVES + k] = CW'(row[k]);
            end
            else
            begin : g_pad
                assign tree[LEAVES + k] = '0;
            end
        end
        for (k = 1; k < LEAVES; k++)
        begin : g_node
            assign tree[k] = tree[2 * k] + tree[2 * k + 1];
        end
    endgenerate

    assign count = tree[1];

endmodule

>>> src/graph_adjacency_euler_check.sv
// Graph adjacency store with edge/vertex edits, degree and count queries, and Euler check.
// Holds an undirected graph of up to MAX_VERTICES vertices as a bit matrix in one RAM
// (one row per vertex, one read and one write port) and serves one request at a time:
// in_stall is high from the accept until the result is loaded into the output register.
// Every request ends with a recount of all in-use rows, after its own work: an edge edit
// reads and rewrites both rows, a degree query reads one row, a vertex delete rewrites
// each remaining row, and the Euler check runs reachability passes over the in-use rows,
// repeating until the reached set stops growing (at most n passes). The single RAM read
// port and the one shared row counter make every row walk read one row at a time.
// No clearing pass is needed after reset: a row is zeroed when its vertex is added.
`timescale 1ns / 1ps

module graph_adjacency_euler_check
    import gaec_pkg::*;
#(
    parameter int MAX_VERTICES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [MODE_W-1:0]   mode,
    input  logic [VERT_W-1:0]   vertex_a,
    input  logic [VERT_W-1:0]   vertex_b,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [VCOUNT_W-1:0] vertex_count,
    output logic [ECOUNT_W-1:0] edge_count,
    output logic [DEGREE_W-1:0] degree,
    output logic                euler_cycle
);

    localparam int N    = MAX_VERTICES;
    localparam int IW   = $clog2(N);
    localparam int NW   = $clog2(N + 1);
    localparam int CW   = $clog2(N + 1);
    localparam int BW   = $clog2(N * N + 1);
    localparam int CMPW = (NW > VERT_W) ? NW : VERT_W;

    state_t state_reg, state_next;

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [VERT_W-1:0] a_reg, a_next;
    logic [VERT_W-1:0] b_reg, b_next;
    logic [NW-1:0]     n_reg, n_next;
    logic [NW-1:0]     idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [IW-1:0]     pend_idx_reg, pend_idx_next;
    logic [N-1:0]      reach_reg, reach_next;
    logic              changed_reg, changed_next;
    logic              parity_ok_reg, parity_ok_next;
    logic [BW-1:0]     bits_reg, bits_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DEGREE_W-1:0] degree_reg, degree_next;
    logic              euler_reg, euler_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [VCOUNT_W-1:0] out_vcount_reg;
    logic [ECOUNT_W-1:0] out_ecount_reg;
    logic [DEGREE_W-1:0] out_degree_reg;
    logic                out_euler_reg;
    logic                out_load;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [N-1:0]  ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [N-1:0]  ram_rdata;
    logic [CW-1:0] row_count;

    logic [CMPW-1:0] a_m1, b_m1;
    logic [IW-1:0]   a_idx, b_idx;
    logic            a_ok, b_ok;
    logic [N-1:0]    mask_a, mask_b;
    logic [N-1:0]    all_mask, keep_mask, shifted_row, merged_reach;
    logic [NW-1:0]   n_m1, del_src;
    logic            scan_issue, scan_done;
    logic [31:0]     count_ext, vcount_ext, ecount_ext;

    gaec_ram #(
        .WIDTH (N),
        .DEPTH (N)
    ) u_adj_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    gaec_popcount #(
        .WIDTH (N)
    ) u_row_count (
        .row   (ram_rdata),
        .count (row_count)
    );

    assign a_m1  = CMPW'(a_reg) - CMPW'(1);
    assign b_m1  = CMPW'(b_reg) - CMPW'(1);
    assign a_idx = a_m1[IW-1:0];
    assign b_idx = b_m1[IW-1:0];
    assign a_ok  = (a_reg != '0) && (CMPW'(a_reg) <= CMPW'(n_reg));
    assign b_ok  = (b_reg != '0) && (CMPW'(b_reg) <= CMPW'(n_reg));

    assign mask_a = {{(N-1){1'b0}}, 1'b1} << a_idx;
    assign mask_b = {{(N-1){1'b0}}, 1'b1} << b_idx;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            all_mask[i]  = (i < int'(n_reg));
            keep_mask[i] = (i < int'(a_idx));
        end
    end

    // drop the deleted column: bits above it move down by one
    assign shifted_row  = (ram_rdata & keep_mask) | ((ram_rdata >> 1) & ~keep_mask);
    assign merged_reach = (reach_reg | ram_rdata) & all_mask;

    assign n_m1    = n_reg - NW'(1);
    assign del_src = (idx_reg < NW'(a_idx)) ? idx_reg : (idx_reg + NW'(1));

    assign scan_issue = (idx_reg < n_reg);
    assign scan_done  = !scan_issue && !pend_reg;

    assign count_ext  = 32'(row_count);
    assign vcount_ext = 32'(n_reg);
    assign ecount_ext = 32'(bits_reg >> 1);

    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        reach_next     = reach_reg;
        changed_next   = changed_reg;
        parity_ok_next = parity_ok_reg;
        bits_next      = bits_reg;
        status_next    = status_reg;
        degree_next    = degree_reg;
        euler_next     = euler_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next   = mode;
                    a_next      = vertex_a;
                    b_next      = vertex_b;
                    status_next = STATUS_OK;
                    degree_next = '0;
                    euler_next  = 1'b0;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (mode_reg)
                    MODE_ADD_VERTEX:
                    begin
                        if (n_reg >= NW'(N))
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            // zero the new row; its column is already clear
                            ram_we    = 1'b1;
                            ram_waddr = n_reg[IW-1:0];
                            n_next    = n_reg + NW'(1);
                        end
                        state_next = S_CNT_SCAN;
                    end
                    MODE_ADD_EDGE, MODE_DEL_EDGE:
                    begin
                        if (!a_ok || !b_ok)
                        begin
                            status_next = STATUS_NO_VERT;
                            state_next  = S_CNT_SCAN;
                        end
                        else
                        begin
                            state_next = S_EDGE_RD_A;
                        end
                    end
                    MODE_DEL_VERTEX:
                    begin
                        if (n_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                            state_next  = S_CNT_SCAN;
                        end
                        else if (!a_ok)
                        begin
                            status_next = STATUS_NO_VERT;
                            state_next  = S_CNT_SCAN;
                        end
                        else if (n_reg == NW'(1))
                        begin
                            n_next     = '0;
                            state_next = S_CNT_SCAN;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_DEL_RD;
                        end
                    end
                    MODE_DEGREE:
                    begin
                        if (!a_ok)
                        begin
                            status_next = STATUS_NO_VERT;
                            state_next  = S_CNT_SCAN;
                        end
                        else
                        begin
                            state_next = S_DEG_RD;
                        end
                    end
                    MODE_EULER:
                    begin
                        reach_next     = {{(N-1){1'b0}}, (n_reg != '0)};
                        changed_next   = 1'b0;
                        parity_ok_next = 1'b1;
                        state_next     = S_EUL_SCAN;
                    end
                    default:
                    begin
                        state_next = S_CNT_SCAN;
                    end
                endcase
            end
            S_EDGE_RD_A:
            begin
                ram_raddr  = a_idx;
                state_next = S_EDGE_WR_A;
            end
            S_EDGE_WR_A:
            begin
                ram_waddr = a_idx;
                if (mode_reg == MODE_ADD_EDGE)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata | mask_b;
                    state_next = S_EDGE_RD_B;
                end
                else if ((ram_rdata & mask_b) == '0)
                begin
                    status_next = STATUS_NO_EDGE;
                    state_next  = S_CNT_SCAN;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata & ~mask_b;
                    state_next = S_EDGE_RD_B;
                end
            end
            S_EDGE_RD_B:
            begin
                ram_raddr  = b_idx;
                state_next = S_EDGE_WR_B;
            end
            S_EDGE_WR_B:
            begin
                ram_we     = 1'b1;
                ram_waddr  = b_idx;
                ram_wdata  = (mode_reg == MODE_ADD_EDGE) ? (ram_rdata | mask_a)
                                                         : (ram_rdata & ~mask_a);
                state_next = S_CNT_SCAN;
            end
            S_DEL_RD:
            begin
                // rows past the deleted one move up by one
                ram_raddr  = del_src[IW-1:0];
                state_next = S_DEL_WR;
            end
            S_DEL_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[IW-1:0];
                ram_wdata = shifted_row;
                idx_next  = idx_reg + NW'(1);
                if ((idx_reg + NW'(1)) < n_m1)
                begin
                    state_next = S_DEL_RD;
                end
                else
                begin
                    n_next     = n_m1;
                    state_next = S_CNT_SCAN;
                end
            end
            S_DEG_RD:
            begin
                ram_raddr  = a_idx;
                state_next = S_DEG_CAP;
            end
            S_DEG_CAP:
            begin
                degree_next = count_ext[DEGREE_W-1:0];
                state_next  = S_CNT_SCAN;
            end
            S_EUL_SCAN:
            begin
                if (scan_issue)
                begin
                    ram_raddr     = idx_reg[IW-1:0];
                    idx_next      = idx_reg + NW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IW-1:0];
                end
                if (pend_reg)
                begin
                    if (reach_reg[pend_idx_reg] && (merged_reach != reach_reg))
                    begin
                        reach_next   = merged_reach;
                        changed_next = 1'b1;
                    end
                    if (row_count[0])
                    begin
                        parity_ok_next = 1'b0;
                    end
                end
                if (scan_done)
                begin
                    if (changed_reg)
                    begin
                        // reached set grew: run another pass
                        idx_next     = '0;
                        changed_next = 1'b0;
                    end
                    else
                    begin
                        euler_next = (n_reg != NW'(1)) && (reach_reg == all_mask)
                                     && parity_ok_reg;
                        state_next = S_CNT_SCAN;
                    end
                end
            end
            S_CNT_SCAN:
            begin
                if (scan_issue)
                begin
                    ram_raddr     = idx_reg[IW-1:0];
                    idx_next      = idx_reg + NW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IW-1:0];
                end
                if (pend_reg)
                begin
                    bits_next = bits_reg + BW'(row_count);
                end
                if (scan_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // restart the row walk on entry to either scan
        if ((state_next == S_CNT_SCAN || state_next == S_EUL_SCAN)
            && (state_reg != state_next))
        begin
            idx_next  = '0;
            pend_next = 1'b0;
            bits_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            changed_reg   <= 1'b0;
            parity_ok_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            changed_reg   <= changed_next;
            parity_ok_reg <= parity_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        pend_idx_reg <= pend_idx_next;
        reach_reg    <= reach_next;
        bits_reg     <= bits_next;
        status_reg   <= status_next;
        degree_reg   <= degree_next;
        euler_reg    <= euler_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_vcount_reg <= vcount_ext[VCOUNT_W-1:0];
            out_ecount_reg <= ecount_ext[ECOUNT_W-1:0];
            out_degree_reg <= degree_reg;
            out_euler_reg  <= euler_reg;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign vertex_count = out_vcount_reg;
    assign edge_count   = out_ecount_reg;
    assign degree       = out_degree_reg;
    assign euler_cycle  = out_euler_reg;

    a_vertex_limit: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= NW'(N))
        else $error("vertex count exceeds capacity");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_DECODE))
        else $error("accepted beat did not reach decode");

    a_pend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (NW'(pend_idx_reg) < n_reg))
        else $error("scan read past in-use rows");

    a_euler_mode_only: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FIN) && (mode_reg != MODE_EULER)) |-> !euler_reg)
        else $error("euler flag set outside euler check");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_DECODE || state_reg == S_EDGE_WR_A
                    || state_reg == S_EDGE_WR_B || state_reg == S_DEL_WR))
        else $error("matrix write outside a write state");

endmodule

>>> tb/tb_graph_adjacency_euler_check.sv
// Self-checking testbench for the graph adjacency store with vertex/edge edits and Euler check.
`timescale 1ns / 1ps

module tb_graph_adjacency_euler_check;
    import gaec_pkg::*;

    localparam int unsigned NV             = 16;
    localparam int unsigned TOTAL_ITEMS    = 1350;
    localparam int unsigned TAIL_ITEMS     = 150;
    localparam int unsigned HOLD_CYCLES    = 400;
    // Worst request is an Euler walk on a full graph, plus a stall burst and the long
    // hold-off; the limit is several times that.
    localparam int unsigned WATCHDOG_LIMIT = 6000;
    localparam int unsigned DRAIN_CYCLES   = 400;

    localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VCOUNT_W-1:0] vcount;
        logic [ECOUNT_W-1:0] ecount;
        logic [DEGREE_W-1:0] deg;
        logic                euler;
    } graph_reply_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [VERT_W-1:0] va;
        logic [VERT_W-1:0] vb;
        logic [4:0]        reps;
        logic              pinned;
        graph_reply_t      want;
    } request_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [MODE_W-1:0]   mode;
    logic [VERT_W-1:0]   vertex_a;
    logic [VERT_W-1:0]   vertex_b;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [VCOUNT_W-1:0] vertex_count;
    logic [ECOUNT_W-1:0] edge_count;
    logic [DEGREE_W-1:0] degree;
    logic                euler_cycle;

    // Shadow of the graph, advanced once per accepted request.
    logic [NV-1:0] adj_rows [NV];
    int unsigned   live_n;

    graph_reply_t  pending [$];
    request_row_t  script [$];

    int unsigned   beats_in;
    int unsigned   results_seen;
    int unsigned   mismatches;
    int unsigned   idle_cycles;
    int unsigned   send_idle_pct;
    int unsigned   euler_passes;
    int unsigned   full_hits;
    int unsigned   peak_edges;
    bit            quiet_tail;
    bit            hold_req;
    bit            hold_active;

    graph_adjacency_euler_check #(
        .MAX_VERTICES(NV)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .vertex_a     (vertex_a),
        .vertex_b     (vertex_b),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .vertex_count (vertex_count),
        .edge_count   (edge_count),
        .degree       (degree),
        .euler_cycle  (euler_cycle)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned row_ones(logic [NV-1:0] bits);
        int unsigned c;
        c = 0;
        for (int i = 0; i < NV; i++)
            c += bits[i];
        return c;
    endfunction

    function automatic bit is_live(logic [VERT_W-1:0] v);
        return v >= 1 && v <= live_n;
    endfunction

    function automatic int unsigned edge_total();
        int unsigned bits;
        bits = 0;
        for (int i = 0; i < NV; i++)
            if (i < live_n)
                bits += row_ones(adj_rows[i]);
        return bits / 2;
    endfunction

    function automatic bit euler_walk();
        logic [NV-1:0] span;
        logic [NV-1:0] reach;
        logic [NV-1:0] grow;
        span  = '0;
        reach = '0;
        for (int i = 0; i < NV; i++)
            if (i < live_n)
                span[i] = 1'b1;
        if (live_n != 0)
            reach[0] = 1'b1;
        // Grow the reached set from vertex 1 until it stops changing.
        for (int k = 0; k < NV; k++)
        begin
            grow = reach;
            for (int i = 0; i < NV; i++)
                if (i < live_n && reach[i])
                    grow |= adj_rows[i];
            grow &= span;
            if (grow == reach)
                break;
            reach = grow;
        end
        if (live_n == 1 || reach != span)
            return 1'b0;
        for (int i = 0; i < NV; i++)
            if (i < live_n && row_ones(adj_rows[i]) % 2 != 0)
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void drop_vertex(int unsigned pos);
        logic [NV-1:0] keep;
        keep = '0;
        for (int i = 0; i < NV; i++)
            if (i < pos)
                keep[i] = 1'b1;
        // Close the gap in every column, then in the rows.
        for (int i = 0; i < NV; i++)
            adj_rows[i] = (adj_rows[i] & keep) | ((adj_rows[i] >> 1) & ~keep);
        for (int i = 0; i < NV - 1; i++)
            if (i >= pos && i + 1 < live_n)
                adj_rows[i] = adj_rows[i + 1];
        adj_rows[live_n - 1] = '0;
        live_n--;
    endfunction

    function automatic graph_reply_t graph_apply(logic [MODE_W-1:0] m, logic [VERT_W-1:0] a,
                                                 logic [VERT_W-1:0] b);
        graph_reply_t r;
        int unsigned  ia;
        int unsigned  ib;
        r  = '0;
        r.status = STATUS_OK;
        ia = a - 1;
        ib = b - 1;
        case (m)
            MODE_ADD_VERTEX:
                if (live_n >= NV)
                    r.status = STATUS_FULL;
                else
                begin
                    live_n++;
                    adj_rows[live_n - 1] = '0;
                    for (int i = 0; i < NV; i++)
                        adj_rows[i][live_n - 1] = 1'b0;
                end
            MODE_ADD_EDGE:
                if (!is_live(a) || !is_live(b))
                    r.status = STATUS_NO_VERT;
                else
                begin
                    adj_rows[ia][ib] = 1'b1;
                    adj_rows[ib][ia] = 1'b1;
                end
            MODE_DEL_VERTEX:
                if (live_n == 0)
                    r.status = STATUS_EMPTY;
                else if (!is_live(a))
                    r.status = STATUS_NO_VERT;
                else
                    drop_vertex(ia);
            MODE_DEL_EDGE:
                if (!is_live(a) || !is_live(b))
                    r.status = STATUS_NO_VERT;
                else if (!adj_rows[ia][ib])
                    r.status = STATUS_NO_EDGE;
                else
                begin
                    adj_rows[ia][ib] = 1'b0;
                    adj_rows[ib][ia] = 1'b0;
                end
            MODE_DEGREE:
                if (!is_live(a))
                    r.status = STATUS_NO_VERT;
                else
                    r.deg = DEGREE_W'(row_ones(adj_rows[ia]));
            MODE_EULER:
                r.euler = euler_walk();
            default:
                ;
        endcase
        r.vcount = VCOUNT_W'(live_n);
        r.ecount = ECOUNT_W'(edge_total());
        return r;
    endfunction

    function automatic graph_reply_t reply(logic [STATUS_W-1:0] st, int unsigned vc,
                                           int unsigned ec, int unsigned dg, bit eu);
        graph_reply_t r;
        r.status = st;
        r.vcount = VCOUNT_W'(vc);
        r.ecount = ECOUNT_W'(ec);
        r.deg    = DEGREE_W'(dg);
        r.euler  = eu;
        return r;
    endfunction

    function automatic request_row_t script_row(logic [MODE_W-1:0] m, logic [VERT_W-1:0] a,
                                                logic [VERT_W-1:0] b, int unsigned reps,
                                                bit pin, graph_reply_t want);
        request_row_t r;
        r.mode   = m;
        r.va     = a;
        r.vb     = b;
        r.reps   = 5'(reps);
        r.pinned = pin;
        r.want   = want;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        if (mismatches < 40)
            $display("MISMATCH at result %0d, %s: got %0d, want %0d",
                     results_seen, what, got, want);
        mismatches++;
    endtask

    // Present one request, hold it until accepted, then log what it should produce.
    task automatic offer(input request_row_t req);
        graph_reply_t got;
        if (!quiet_tail && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= req.mode;
        vertex_a <= req.va;
        vertex_b <= req.vb;
        do @(posedge clk); while (in_stall !== 1'b0);
        got = graph_apply(req.mode, req.va, req.vb);
        pending.push_back(req.pinned ? req.want : got);
        if (got.euler)
            euler_passes++;
        if (got.status == STATUS_FULL)
            full_hits++;
        if (got.ecount > peak_edges)
            peak_edges = got.ecount;
        beats_in++;
        quiet_tail = (beats_in >= TOTAL_ITEMS - TAIL_ITEMS);
    endtask

    task automatic send(input logic [MODE_W-1:0] m, input logic [VERT_W-1:0] a,
                        input logic [VERT_W-1:0] b);
        offer(script_row(m, a, b, 1, 1'b0, '0));
    endtask

    task automatic send_edge(input int unsigned a, input int unsigned b);
        if ($urandom_range(0, 1))
            send(MODE_ADD_EDGE, VERT_W'(a), VERT_W'(b));
        else
            send(MODE_ADD_EDGE, VERT_W'(b), VERT_W'(a));
    endtask

    function automatic logic [VERT_W-1:0] pick_vertex();
        if ($urandom_range(0, 9) == 0)
            return VERT_W'($urandom_range(0, 31));
        return VERT_W'($urandom_range(1, (live_n == 0) ? 1 : live_n));
    endfunction

    task automatic random_request(input int unsigned cap);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 14)
            send((live_n < cap) ? MODE_ADD_VERTEX : MODE_DEL_VERTEX,
                 pick_vertex(), pick_vertex());
        else if (r < 44)
            send(MODE_ADD_EDGE, pick_vertex(), pick_vertex());
        else if (r < 52)
            send(MODE_DEL_VERTEX, pick_vertex(), pick_vertex());
        else if (r < 66)
            send(MODE_DEL_EDGE, pick_vertex(), pick_vertex());
        else if (r < 78)
            send(MODE_DEGREE, pick_vertex(), pick_vertex());
        else if (r < 83)
            send(MODE_COUNTS, pick_vertex(), pick_vertex());
        else if (r < 97)
            send(MODE_EULER, pick_vertex(), pick_vertex());
        else
            send(MODE_SPARE, pick_vertex(), pick_vertex());
    endtask

    // Rebuild a ring of k vertices, maybe perturb it, then send an Euler and a degree query.
    task automatic ring_sequence(input int unsigned k);
        while (live_n != 0)
            send(MODE_DEL_VERTEX, VERT_W'($urandom_range(1, live_n)), VERT_W'($urandom));
        repeat (k) send(MODE_ADD_VERTEX, VERT_W'($urandom), VERT_W'($urandom));
        for (int unsigned i = 1; i < k; i++)
            send_edge(i, i + 1);
        if (k >= 3)
            send_edge(k, 1);
        case ($urandom_range(0, 4))
            0:
                if (k >= 2)
                    send(MODE_DEL_EDGE, VERT_W'(1), VERT_W'(2));
            1:
                send(MODE_ADD_EDGE, pick_vertex(), pick_vertex());
            2:
                if (k >= 5)
                begin
                    // a triangle keeps every degree even unless one of its edges is already a ring edge
                    send_edge(1, 3);
                    send_edge(3, 5);
                    send_edge(5, 1);
                end
            default:
                ;
        endcase
        send(MODE_EULER, pick_vertex(), pick_vertex());
        send(MODE_DEGREE, pick_vertex(), pick_vertex());
    endtask

    task automatic dense_phase();
        ring_sequence(NV);
        send(MODE_ADD_VERTEX, VERT_W'($urandom), VERT_W'($urandom));
        repeat (110)
        begin
            send_edge($urandom_range(1, NV), $urandom_range(1, NV));
            if ($urandom_range(0, 9) == 0)
                send(MODE_EULER, pick_vertex(), pick_vertex());
            else if ($urandom_range(0, 9) == 0)
                send(MODE_DEGREE, pick_vertex(), pick_vertex());
        end
        send(MODE_EULER, pick_vertex(), pick_vertex());
        send(MODE_COUNTS, pick_vertex(), pick_vertex());
        repeat (30) random_request(NV);
    endtask

    initial
    begin : stimulus
        int unsigned sel;
        bit          hold_done;
        bit          drain_done;
        bit          dense_done;
        hold_done     = 1'b0;
        drain_done    = 1'b0;
        dense_done    = 1'b0;
        beats_in      = 0;
        send_idle_pct = 10;
        quiet_tail    = 1'b0;
        hold_req      = 1'b0;
        hold_active   = 1'b0;
        euler_passes  = 0;
        full_hits     = 0;
        peak_edges    = 0;
        live_n        = 0;
        for (int i = 0; i < NV; i++)
            adj_rows[i] = '0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        mode     <= MODE_COUNTS;
        vertex_a <= '0;
        vertex_b <= '0;

        script.push_back(script_row(MODE_COUNTS,     5'd0,  5'd0,  1,  1,
                                    reply(STATUS_OK,      0, 0, 0, 1'b0)));
        script.push_back(script_row(MODE_EULER,      5'd0,  5'd0,  1,  1,
                                    reply(STATUS_OK,      0, 0, 0, 1'b1)));
        script.push_back(script_row(MODE_DEL_VERTEX, 5'd1,  5'd0,  1,  1,
                                    reply(STATUS_EMPTY,   0, 0, 0, 1'b0)));
        script.push_back(script_row(MODE_DEGREE,     5'd1,  5'd0,  1,  1,
                                    reply(STATUS_NO_VERT, 0, 0, 0, 1'b0)));
        script.push_back(script_row(MODE_ADD_EDGE,   5'd1,  5'd1,  1,  1,
                                    reply(STATUS_NO_VERT, 0, 0, 0, 1'b0)));
        script.push_back(script_row(MODE_ADD_VERTEX, 5'd0,  5'd0,  1,  1,
                                    reply(STATUS_OK,      1, 0, 0, 1'b0)));
        script.push_back(script_row(MODE_EULER,      5'd0,  5'd0,  1,  1,
                                    reply(STATUS_OK,      1, 0, 0, 1'b0)));
        script.push_back(script_row(MODE_ADD_EDGE,   5'd1,  5'd1,  1,  1,
                                    reply(STATUS_OK,      1, 0, 0, 1'b0)));
        script.push_back(script_row(MODE_DEGREE,     5'd1,  5'd0,  1,  1,
                                    reply(STATUS_OK,      1, 0, 1, 1'b0)));
        script.push_back(script_row(MODE_DEL_VERTEX, 5'd2,  5'd0,  1,  1,
                                    reply(STATUS_NO_VERT, 1, 0, 0, 1'b0)));
        script.push_back(script_row(MODE_DEL_VERTEX, 5'd0,  5'd0,  1,  1,
                                    reply(STATUS_NO_VERT, 1, 0, 0, 1'b0)));
        script.push_back(script_row(MODE_ADD_VERTEX, 5'd31, 5'd31, 15, 0, '0));
        script.push_back(script_row(MODE_ADD_VERTEX, 5'd0,  5'd0,  1,  1,
                                    reply(STATUS_FULL,   16, 0, 0, 1'b0)));
        script.push_back(script_row(MODE_ADD_EDGE,   5'd16, 5'd16, 1,  1,
                                    reply(STATUS_OK,     16, 1, 0, 1'b0)));
        script.push_back(script_row(MODE_ADD_EDGE,   5'd1,  5'd16, 1,  1,
                                    reply(STATUS_OK,     16, 2, 0, 1'b0)));
        script.push_back(script_row(MODE_DEGREE,     5'd16, 5'd0,  1,  1,
                                    reply(STATUS_OK,     16, 2, 2, 1'b0)));
        script.push_back(script_row(MODE_EULER,      5'd0,  5'd0,  1,  0, '0));
        script.push_back(script_row(MODE_DEL_EDGE,   5'd2,  5'd3,  1,  1,
                                    reply(STATUS_NO_EDGE, 16, 2, 0, 1'b0)));
        script.push_back(script_row(MODE_ADD_EDGE,   5'd31, 5'd17, 1,  1,
                                    reply(STATUS_NO_VERT, 16, 2, 0, 1'b0)));
        script.push_back(script_row(MODE_DEL_EDGE,   5'd16, 5'd31, 1,  1,
                                    reply(STATUS_NO_VERT, 16, 2, 0, 1'b0)));
        script.push_back(script_row(MODE_DEL_EDGE,   5'd16, 5'd1,  1,  0, '0));
        script.push_back(script_row(MODE_SPARE,      5'd7,  5'd9,  1,  0, '0));
        script.push_back(script_row(MODE_DEL_VERTEX, 5'd1,  5'd0,  1,  0, '0));
        script.push_back(script_row(MODE_DEL_VERTEX, 5'd15, 5'd0,  1,  0, '0));
        script.push_back(script_row(MODE_EULER,      5'd0,  5'd0,  1,  0, '0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            repeat (script[i].reps) offer(script[i]);

        while (beats_in < TOTAL_ITEMS)
        begin
            if (!hold_done && beats_in >= 300)
            begin
                // keep offering while the sink holds off, so the block backs up
                hold_done = 1'b1;
                hold_req  = 1'b1;
                in_valid <= 1'b0;
                while (!hold_active)
                    @(posedge clk);
                while (hold_active)
                    random_request(8);
            end
            else if (!dense_done && beats_in >= 500)
            begin
                dense_done = 1'b1;
                dense_phase();
            end
            else if (!drain_done && beats_in >= 800)
            begin
                drain_done = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending.size() != 0)
                    @(posedge clk);
            end
            else
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       send_idle_pct = 0;
                        1:       send_idle_pct = 8;
                        default: send_idle_pct = 30;
                    endcase
                end
                sel = $urandom_range(0, 99);
                if (sel < 60)
                    repeat ($urandom_range(1, 8)) random_request(8);
                else if (sel < 85)
                    ring_sequence($urandom_range(0, 7));
                else if (sel < 92)
                begin
                    while (live_n > 2)
                        send(MODE_DEL_VERTEX, pick_vertex(), pick_vertex());
                end
                else
                begin
                    repeat ($urandom_range(1, 6))
                        send(MODE_W'($urandom_range(0, 7)), VERT_W'($urandom_range(0, 31)),
                             VERT_W'($urandom_range(0, 31)));
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests, checked %0d results, mismatches %0d.",
                 beats_in, results_seen, mismatches);
        $display("Euler checks passed %0d times, full rejections %0d, peak edge count %0d.",
                 euler_passes, full_hits, peak_edges);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : result_sink
        int unsigned pick;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (quiet_tail)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if (hold_req)
            begin
                hold_active = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req    = 1'b0;
                hold_active = 1'b0;
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 19)) @(posedge clk);
                    out_stall <= 1'b0;
                    @(posedge clk);
                end
                else if (pick < 8)
                begin
                    out_stall <= 1'b0;
                    repeat ($urandom_range(1, 30)) @(posedge clk);
                end
                else
                begin
                    out_stall <= 1'b0;
                    repeat ($urandom_range(50, 250)) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        graph_reply_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            results_seen++;
            if (pending.size() == 0)
                note_mismatch("result beat with no request pending", 1, 0);
            else
            begin
                want = pending.pop_front();
                if (status !== want.status)
                    note_mismatch("status", status, want.status);
                if (vertex_count !== want.vcount)
                    note_mismatch("vertex_count", vertex_count, want.vcount);
                if (edge_count !== want.ecount)
                    note_mismatch("edge_count", edge_count, want.ecount);
                if (degree !== want.deg)
                    note_mismatch("degree", degree, want.deg);
                if (euler_cycle !== want.euler)
                    note_mismatch("euler_cycle", euler_cycle, want.euler);
            end
        end
    end

    initial
    begin
        results_seen = 0;
        mismatches   = 0;
        idle_cycles  = 0;
    end

    // Drop out if neither side moves a beat for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no beat moved for %0d cycles, %0d results pending.",
                     idle_cycles, pending.size());
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

>>> filelist.f
src/gaec_pkg.sv
src/gaec_ram.sv
src/gaec_popcount.sv
src/graph_adjacency_euler_check.sv
tb/tb_graph_adjacency_euler_check.sv
